// ----- hw/rtl/p8cpu_pkg.sv -----
// Shared types and constants of the paged 8-bit CPU core.
package p8cpu_pkg;

   // Opcode groups (instruction bits 7:4)
   localparam logic [3:0] OP_SYS       = 4'h0;
   localparam logic [3:0] OP_SUB       = 4'h1;
   localparam logic [3:0] OP_LOAD      = 4'h2;
   localparam logic [3:0] OP_STORE     = 4'h3;
   localparam logic [3:0] OP_SKIP      = 4'h4;
   localparam logic [3:0] OP_JALR      = 4'h5;
   localparam logic [3:0] OP_NAND      = 4'h6;
   localparam logic [3:0] OP_ADD       = 4'h7;
   localparam logic [3:0] OP_UNARY     = 4'h8;
   localparam logic [3:0] OP_JMPFAR    = 4'h9;
   localparam logic [3:0] OP_STACK     = 4'hA;
   localparam logic [3:0] OP_ILLEGAL   = 4'hB;
   localparam logic [3:0] OP_SLI_FIRST = 4'hC;
   localparam logic [3:0] OP_SLI_LAST  = 4'hF;

   // Sub-codes (instruction bits 1:0)
   localparam logic [1:0] SYS_HALT  = 2'd1;
   localparam logic [1:0] SYS_PAGE  = 2'd3;
   localparam logic [1:0] SKIP_Z    = 2'd0;
   localparam logic [1:0] SKIP_NZ   = 2'd1;
   localparam logic [1:0] SKIP_L    = 2'd2;
   localparam logic [1:0] SKIP_GE   = 2'd3;
   localparam logic [1:0] UN_INC    = 2'd0;
   localparam logic [1:0] UN_DEC    = 2'd1;
   localparam logic [1:0] UN_OUT    = 2'd2;
   localparam logic [1:0] UN_IN     = 2'd3;
   localparam logic [1:0] STK_PUSH  = 2'd0;
   localparam logic [1:0] STK_POP   = 2'd1;
   localparam logic [1:0] STK_PAGE  = 2'd2;

   localparam logic [1:0] REG_C = 2'd2;

   localparam logic [7:0] ROM_LIMIT = 8'h80;
   localparam logic [7:0] FILL_BYTE = 8'hFF;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_CR   = 8'h0D;

   // Configuration registers
   localparam int         CSR_ADDR_W    = 3;
   localparam logic [0:0] REG_TEXT_MODE = 1'b0;

   // Stream word layout
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_DECODE,
      ST_MEMRD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic load_write;
      logic fetch;
      logic execute;
      logic mem_wb;
      logic post;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic halted;
      logic clear_last;
      logic needs_rd;
      logic rsp_free;
   } status_type;

endpackage

// ----- hw/rtl/p8cpu_ram.sv -----
// Generic single-port RAM with registered read.
module p8cpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/p8cpu_ctrl.sv -----
// Sequencing state machine of the CPU core.
module p8cpu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  p8cpu_pkg::status_type  status,
   output p8cpu_pkg::cmd_type     cmd
);

   p8cpu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= p8cpu_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         p8cpu_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = p8cpu_pkg::ST_IDLE;
         end
         p8cpu_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = p8cpu_pkg::ST_FETCH;
         end
         p8cpu_pkg::ST_FETCH: begin
            if (status.is_load || status.halted) state_in = p8cpu_pkg::ST_DONE;
            else                                 state_in = p8cpu_pkg::ST_DECODE;
         end
         p8cpu_pkg::ST_DECODE: begin
            if (status.needs_rd) state_in = p8cpu_pkg::ST_MEMRD;
            else                 state_in = p8cpu_pkg::ST_DONE;
         end
         p8cpu_pkg::ST_MEMRD: begin
            state_in = p8cpu_pkg::ST_DONE;
         end
         p8cpu_pkg::ST_DONE: begin
            if (status.rsp_free) state_in = p8cpu_pkg::ST_IDLE;
         end
         default: state_in = p8cpu_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         p8cpu_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         p8cpu_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         p8cpu_pkg::ST_FETCH: begin
            cmd.load_write = status.is_load;
            cmd.fetch      = !status.is_load && !status.halted;
         end
         p8cpu_pkg::ST_DECODE: cmd.execute = 1'b1;
         p8cpu_pkg::ST_MEMRD:  cmd.mem_wb  = 1'b1;
         p8cpu_pkg::ST_DONE:   cmd.post    = status.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

// ----- hw/rtl/p8cpu_dpath.sv -----
// Architectural registers, execute logic, memory addressing and result register.
module p8cpu_dpath #(
   parameter int MEM_BYTES = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   input  p8cpu_pkg::cmd_type                cmd,
   output p8cpu_pkg::status_type             status,
   input  logic                              text_mode,
   input  logic [p8cpu_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [p8cpu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                              ram_we,
   output logic [$clog2(MEM_BYTES)-1:0]      ram_addr,
   output logic [7:0]                        ram_wdata,
   input  logic [7:0]                        ram_rdata
);

   localparam int AW = $clog2(MEM_BYTES);

   // architectural state
   logic [7:0] gpr_ff [4];
   logic [7:0] gpr_in [4];
   logic [7:0] pc_ff, pc_in, sp_ff, sp_in;
   logic [7:0] dpage_ff, dpage_in, cpage_ff, cpage_in, spage_ff, spage_in;
   logic       halt_ff, halt_in;

   // captured item
   logic        op_ff;
   logic [15:0] laddr_ff;
   logic [7:0]  ldata_ff, cin_ff;

   // per-item flags
   logic       outv_ff, outv_in, int_ff, int_in, ill_ff, ill_in;
   logic [7:0] outd_ff, outd_in;
   logic [1:0] rd_ff;

   logic [AW-1:0] clr_ff;
   logic          rsp_valid_ff;
   logic [p8cpu_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // decode of the fetched byte
   logic [3:0]  op;
   logic [1:0]  rd, rs;
   logic [3:0]  imm;
   logic [7:0]  dval, sval, pc_inc, cin_map;
   logic        take;
   logic [15:0] phys;

   assign op     = ram_rdata[7:4];
   assign rd     = ram_rdata[3:2];
   assign rs     = ram_rdata[1:0];
   assign imm    = {ram_rdata[5:4], ram_rdata[1:0]};
   assign dval   = gpr_ff[rd];
   assign sval   = gpr_ff[rs];
   assign pc_inc = pc_ff + 8'd1;
   assign cin_map = (text_mode && cin_ff == p8cpu_pkg::CHAR_LF) ? p8cpu_pkg::CHAR_CR : cin_ff;

   always_comb begin
      case (rs)
         p8cpu_pkg::SKIP_Z:  take = (dval == 8'd0);
         p8cpu_pkg::SKIP_NZ: take = (dval != 8'd0);
         p8cpu_pkg::SKIP_L:  take = dval[7];
         p8cpu_pkg::SKIP_GE: take = !dval[7];
         default:            take = 1'b0;
      endcase
   end

   // execute
   always_comb begin
      gpr_in   = gpr_ff;
      pc_in    = pc_ff;
      sp_in    = sp_ff;
      dpage_in = dpage_ff;
      cpage_in = cpage_ff;
      spage_in = spage_ff;
      halt_in  = halt_ff;
      outv_in  = outv_ff;
      outd_in  = outd_ff;
      int_in   = int_ff;
      ill_in   = ill_ff;
      if (cmd.capture) begin
         outv_in = 1'b0;
         outd_in = 8'd0;
         int_in  = 1'b0;
         ill_in  = 1'b0;
      end
      if (cmd.mem_wb) begin
         gpr_in[rd_ff] = ram_rdata;
      end
      if (cmd.execute) begin
         pc_in = pc_inc;
         case (op) inside
            p8cpu_pkg::OP_SYS: begin
               if (rs == p8cpu_pkg::SYS_HALT)      halt_in  = 1'b1;
               else if (rs == p8cpu_pkg::SYS_PAGE) dpage_in = dval;
            end
            p8cpu_pkg::OP_SUB:   gpr_in[rd] = dval - sval;
            p8cpu_pkg::OP_LOAD, p8cpu_pkg::OP_STORE: ;
            p8cpu_pkg::OP_SKIP: begin
               if (take) pc_in = pc_inc + 8'd1;
            end
            p8cpu_pkg::OP_JALR: begin
               pc_in      = sval;
               gpr_in[rd] = pc_inc;
            end
            p8cpu_pkg::OP_NAND:  gpr_in[rd] = ~(dval & sval);
            p8cpu_pkg::OP_ADD:   gpr_in[rd] = dval + sval;
            p8cpu_pkg::OP_UNARY: begin
               case (rs)
                  p8cpu_pkg::UN_INC: gpr_in[rd] = dval + 8'd1;
                  p8cpu_pkg::UN_DEC: gpr_in[rd] = dval - 8'd1;
                  p8cpu_pkg::UN_OUT: begin
                     outv_in = 1'b1;
                     outd_in = dval;
                  end
                  default: begin
                     gpr_in[rd] = cin_map;
                     int_in     = 1'b1;
                  end
               endcase
            end
            p8cpu_pkg::OP_JMPFAR: begin
               cpage_in   = gpr_ff[p8cpu_pkg::REG_C];
               pc_in      = sval;
               gpr_in[rd] = pc_inc;
            end
            p8cpu_pkg::OP_STACK: begin
               if (rs == p8cpu_pkg::STK_PUSH)      sp_in    = sp_ff - 8'd1;
               else if (rs == p8cpu_pkg::STK_POP)  sp_in    = sp_ff + 8'd1;
               else if (rs == p8cpu_pkg::STK_PAGE) spage_in = dval;
            end
            p8cpu_pkg::OP_ILLEGAL: ill_in = 1'b1;
            [p8cpu_pkg::OP_SLI_FIRST:p8cpu_pkg::OP_SLI_LAST]: gpr_in[rd] = {dval[3:0], imm};
            default: ;
         endcase
      end
   end

   // memory port
   always_comb begin
      phys      = {cpage_ff, pc_ff};
      ram_we    = 1'b0;
      ram_wdata = dval;
      if (cmd.clear_step) begin
         phys      = 16'(clr_ff);
         ram_we    = 1'b1;
         ram_wdata = p8cpu_pkg::FILL_BYTE;
      end else if (cmd.load_write) begin
         phys      = laddr_ff;
         ram_we    = 1'b1;
         ram_wdata = ldata_ff;
      end else if (cmd.fetch) begin
         phys = {cpage_ff, pc_ff};
      end else if (cmd.execute) begin
         case (op)
            p8cpu_pkg::OP_LOAD:  phys = {dpage_ff, sval};
            p8cpu_pkg::OP_STORE: begin
               phys   = {dpage_ff, sval};
               ram_we = (dpage_ff >= p8cpu_pkg::ROM_LIMIT);
            end
            p8cpu_pkg::OP_STACK: begin
               if (rs == p8cpu_pkg::STK_PUSH) begin
                  phys   = {spage_ff, sp_ff - 8'd1};
                  ram_we = (spage_ff >= p8cpu_pkg::ROM_LIMIT);
               end else begin
                  phys = {spage_ff, sp_ff};
               end
            end
            default: phys = {cpage_ff, pc_ff};
         endcase
      end
   end

   assign ram_addr = phys[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         gpr_ff       <= '{default: 8'd0};
         pc_ff        <= 8'd0;
         sp_ff        <= 8'd0;
         dpage_ff     <= 8'd0;
         cpage_ff     <= 8'd0;
         spage_ff     <= 8'd0;
         halt_ff      <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gpr_ff   <= gpr_in;
         pc_ff    <= pc_in;
         sp_ff    <= sp_in;
         dpage_ff <= dpage_in;
         cpage_ff <= cpage_in;
         spage_ff <= spage_in;
         halt_ff  <= halt_in;
         if (cmd.clear_step) clr_ff <= clr_ff + AW'(1);
         if (cmd.post)            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)     rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_tuser[0];
         laddr_ff <= req_tdata[15:0];
         ldata_ff <= req_tdata[23:16];
         cin_ff   <= req_tdata[31:24];
      end
      if (cmd.execute) rd_ff <= rd;
      outv_ff <= outv_in;
      outd_ff <= outd_in;
      int_ff  <= int_in;
      ill_ff  <= ill_in;
      if (cmd.post) begin
         rsp_data_ff <= {4'd0, pc_ff, ill_ff, int_ff, outd_ff, outv_ff, halt_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      status.is_load    = !op_ff;
      status.halted     = halt_ff;
      status.clear_last = (clr_ff == {AW{1'b1}});
      status.needs_rd   = (op == p8cpu_pkg::OP_LOAD) ||
                          (op == p8cpu_pkg::OP_STACK && rs == p8cpu_pkg::STK_POP);
      status.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

endmodule

// ----- hw/rtl/paged_8bit_cpu_core.sv -----
// Top level of the paged 8-bit CPU core: CSR port, controller, datapath and main memory.
//
// Each input word either writes one byte of main memory (tuser 0) or executes one
// instruction (tuser 1), and every word yields exactly one result word. The core
// handles one word at a time around a single-port memory with registered read:
// a load word passes through capture, write and post, an instruction through capture,
// fetch, execute and post, and LOAD or POP add a write-back step, since their data
// byte needs a second memory read. A halted step goes from capture straight to post.
// The result register lets a new word be accepted while the previous result still
// waits to be taken. After reset the core sweeps all MEM_BYTES (65536) bytes of
// memory to 0xFF, one byte per cycle, and holds off input words until the sweep ends;
// the CSR port is live throughout. Stores and pushes to pages below 0x80 are dropped.
module paged_8bit_cpu_core #(
   parameter int MEM_BYTES = 65536
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // load_address [15:0], load_data [23:16], console_in [31:24]
   input  logic [p8cpu_pkg::REQ_DATA_W-1:0]          req_tdata,
   // operation [0]
   input  logic [0:0]                                req_tuser,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // halted [0], out_valid [1], out_data [9:2], in_taken [10], illegal [11],
   // pc_after [19:12], zero pad [23:20]
   output logic [p8cpu_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [p8cpu_pkg::CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [31:0]                               csr_pwdata,
   output logic [31:0]                               csr_prdata,
   output logic                                      csr_pready
);

   localparam int AW = $clog2(MEM_BYTES);

   p8cpu_pkg::cmd_type    cmd;
   p8cpu_pkg::status_type status;

   logic          text_mode_ff;
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_wdata, ram_rdata;
   logic          csr_sel_text;

   // CSR: single text_mode register at word index 0
   assign csr_pready   = 1'b1;
   assign csr_sel_text = (csr_paddr[2] == p8cpu_pkg::REG_TEXT_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         text_mode_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_text) begin
         text_mode_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = csr_sel_text ? {31'd0, text_mode_ff} : 32'd0;

   p8cpu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   p8cpu_dpath #(
      .MEM_BYTES (MEM_BYTES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .text_mode  (text_mode_ff),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .ram_we     (ram_we),
      .ram_addr   (ram_addr),
      .ram_wdata  (ram_wdata),
      .ram_rdata  (ram_rdata)
   );

   p8cpu_ram #(
      .WIDTH (8),
      .DEPTH (MEM_BYTES)
   ) u_mem (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Program writes never land in the ROM half.
   a_rom_protect: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && ram_we) |-> ram_addr[AW-1])
      else $error("program write into ROM half");

   // Once halted, the core stays halted until reset.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      status.halted |=> status.halted)
      else $error("halt flag dropped");

   // A result appears only when the controller posts one.
   a_rsp_from_post: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.post))
      else $error("result raised without post");

   // No item is taken during the memory sweep.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !req_tready)
      else $error("item accepted during memory sweep");

endmodule
